/* rtl/tcd_pkg.sv */
package tcd_pkg;

    localparam int CMD_COUNT    = 8;
    localparam int PREFIX_SLOTS = 8;
    localparam int BYTE_W       = 8;
    localparam int CODE_W       = 4;
    localparam int ARG_W        = 16;

    // command codes as they appear on the result channel
    localparam logic [CODE_W-1:0] CMD_NONE    = 4'd0;
    localparam logic [CODE_W-1:0] CMD_VERSION = 4'd1;
    localparam logic [CODE_W-1:0] CMD_RESET   = 4'd2;
    localparam logic [CODE_W-1:0] CMD_STOP    = 4'd3;
    localparam logic [CODE_W-1:0] CMD_START   = 4'd4;
    localparam logic [CODE_W-1:0] CMD_MODE    = 4'd5;
    localparam logic [CODE_W-1:0] CMD_PERIOD  = 4'd6;
    localparam logic [CODE_W-1:0] CMD_DUTY    = 4'd7;
    localparam logic [CODE_W-1:0] CMD_TIME    = 4'd8;

    // mask bit of the period command, which restarts its argument later
    localparam int PERIOD_BIT = 5;

    localparam logic [BYTE_W-1:0] PREFIX_TEXT [CMD_COUNT][PREFIX_SLOTS] = '{
        '{"v", "e", "r", "s", "i", "o", "n", 8'h00},
        '{"r", "e", "s", "e", "t", 8'h00, 8'h00, 8'h00},
        '{"s", "t", "o", "p", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"s", "t", "a", "r", "t", 8'h00, 8'h00, 8'h00},
        '{"m", "o", "d", "e", ":", 8'h00, 8'h00, 8'h00},
        '{"p", "e", "r", "i", "o", "d", ":", 8'h00},
        '{"d", "u", "t", "y", ":", 8'h00, 8'h00, 8'h00},
        '{"t", "i", "m", "e", ":", 8'h00, 8'h00, 8'h00}
    };

    localparam logic [BYTE_W-1:0] PREFIX_LEN [CMD_COUNT] = '{
        8'd7, 8'd5, 8'd4, 8'd5, 8'd5, 8'd7, 8'd5, 8'd5
    };

    // argument parse starts at the byte after "mode:" style prefixes,
    // and again after "period:"
    localparam logic [BYTE_W-1:0] ARG_START_SHORT = 8'd5;
    localparam logic [BYTE_W-1:0] ARG_START_LONG  = 8'd7;

    typedef enum logic [2:0] {
        PH_SKIP = 3'b001,
        PH_NUM  = 3'b010,
        PH_END  = 3'b100
    } phase_t;

    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] cmd_code;
        logic [ARG_W-1:0]  argument;
    } result_t;

endpackage

/* rtl/tcd_in_reg.sv */
module tcd_in_reg
    import tcd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_byte,
    input  logic              advance,
    output logic              byte_valid,
    output logic [BYTE_W-1:0] byte_data
);

    logic              valid_reg;
    logic [BYTE_W-1:0] data_reg;

    assign s_tready   = !valid_reg || advance;
    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            data_reg <= s_byte;
        end
    end

endmodule

/* rtl/tcd_core.sv */
module tcd_core
    import tcd_pkg::*;
#(
    parameter int MESSAGE_BYTES = 16
)
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              byte_valid,
    input  logic [BYTE_W-1:0] byte_data,
    input  logic              advance,
    output result_t           result
);

    localparam int PW = $clog2(MESSAGE_BYTES);
    localparam logic [PW-1:0] POS_LAST = PW'(MESSAGE_BYTES - 1);

    logic [PW-1:0]        pos_reg, pos_next;
    logic [CMD_COUNT-1:0] mask_reg, mask_next;
    phase_t               phase_reg, phase_next;
    logic                 neg_reg, neg_next;
    logic [ARG_W-1:0]     acc_reg, acc_next;

    logic [CMD_COUNT-1:0] mask_upd;
    phase_t               ph;
    logic                 neg;
    logic [ARG_W-1:0]     acc;
    logic [BYTE_W-1:0]    pos8;
    logic                 is_blank;
    logic                 is_digit;
    logic                 feed_digit;
    logic                 is_term;
    logic [CODE_W-1:0]    code;
    logic [ARG_W-1:0]     val;

    assign pos8     = BYTE_W'(pos_reg);
    assign is_term  = (byte_data == '0);
    assign is_blank = (byte_data == 8'd32) || (byte_data inside {[8'd9:8'd13]});
    assign is_digit = byte_data inside {["0":"9"]};

    always_comb begin
        mask_upd = mask_reg;
        for (int k = 0; k < CMD_COUNT; k++) begin
            if (pos8 < PREFIX_LEN[k] && byte_data != PREFIX_TEXT[k][pos_reg[2:0]]) begin
                mask_upd[k] = 1'b0;
            end
        end
    end

    // atoi style parse: blanks, optional sign, then digits
    always_comb begin
        ph         = phase_reg;
        neg        = neg_reg;
        acc        = acc_reg;
        feed_digit = 1'b0;
        if (pos8 == ARG_START_SHORT ||
            (pos8 == ARG_START_LONG && mask_upd[PERIOD_BIT])) begin
            ph  = PH_SKIP;
            neg = 1'b0;
            acc = '0;
        end
        if (pos8 >= ARG_START_SHORT) begin
            case (ph)
                PH_SKIP: begin
                    if (byte_data == "-") begin
                        neg = 1'b1;
                        ph  = PH_NUM;
                    end else if (byte_data == "+") begin
                        ph = PH_NUM;
                    end else if (!is_blank) begin
                        ph         = PH_NUM;
                        feed_digit = 1'b1;
                    end
                end
                PH_NUM:  feed_digit = 1'b1;
                PH_END:  ;
                default: ;
            endcase
            if (feed_digit) begin
                if (is_digit) begin
                    acc = (acc << 3) + (acc << 1) + ARG_W'(byte_data - "0");
                end else begin
                    ph = PH_END;
                end
            end
        end
    end

    always_comb begin
        code = CMD_NONE;
        for (int k = CMD_COUNT - 1; k >= 0; k--) begin
            if (mask_upd[k]) begin
                code = CODE_W'(k + 1);
            end
        end
        val = neg ? (ARG_W'(0) - acc) : acc;
        result.valid    = byte_valid && is_term;
        result.cmd_code = code;
        case (code)
            CMD_MODE, CMD_DUTY:   result.argument = {8'h00, val[7:0]};
            CMD_PERIOD, CMD_TIME: result.argument = val;
            default:              result.argument = '0;
        endcase
    end

    always_comb begin
        if (is_term || pos_reg == POS_LAST) begin
            pos_next   = '0;
            mask_next  = '1;
            phase_next = PH_SKIP;
            neg_next   = 1'b0;
            acc_next   = '0;
        end else begin
            pos_next   = pos_reg + 1'b1;
            mask_next  = mask_upd;
            phase_next = ph;
            neg_next   = neg;
            acc_next   = acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            mask_reg  <= '1;
            phase_reg <= PH_SKIP;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
        end else if (advance) begin
            pos_reg   <= pos_next;
            mask_reg  <= mask_next;
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
        end
    end

endmodule

/* rtl/tcd_out_reg.sv */
module tcd_out_reg
    import tcd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  result_t           result,
    input  logic              load,
    output logic              load_ready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [CODE_W-1:0] cmd_code,
    output logic [ARG_W-1:0]  argument
);

    logic              valid_reg;
    logic [CODE_W-1:0] code_reg;
    logic [ARG_W-1:0]  arg_reg;

    assign load_ready = !valid_reg || m_tready;
    assign m_tvalid   = valid_reg;
    assign cmd_code   = code_reg;
    assign argument   = arg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load_ready) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && load_ready) begin
            code_reg <= result.cmd_code;
            arg_reg  <= result.argument;
        end
    end

endmodule

/* rtl/text_command_decoder.sv */
// text command decoder
// s_ channel: one received character per transaction in s_tdata; a zero
// byte ends the message. m_ channel: one transaction per terminated message
// carrying the command code and its decimal argument (0 when none).
// a message that reaches MESSAGE_BYTES bytes without a zero is dropped and
// gathering starts over at the next byte.
// a terminator accepted into the input register passes through the parse logic
// to the result register, which drives m_tvalid, once that register is free.
// throughput: one character per cycle; the parse state updates in a single
// pass per byte, so s_tready stays high while the result register is free.
// when the receiver stalls, the pending result holds in the result register
// and only the next terminator waits on it; ordinary characters keep flowing.
// reset (aresetn low at a clock edge) empties both registers and returns the
// parse state to the start of a message.
module text_command_decoder
    import tcd_pkg::*;
#(
    parameter int MESSAGE_BYTES = 16
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [3:0] cmd_code, [19:4] argument, [23:20] zero
);

    logic              byte_valid;
    logic [BYTE_W-1:0] byte_data;
    logic              advance;
    logic              load_ready;
    result_t           result;
    logic [CODE_W-1:0] cmd_code;
    logic [ARG_W-1:0]  argument;

    // a byte moves on unless it ends a message and the result slot is busy
    assign advance = byte_valid && (!result.valid || load_ready);

    tcd_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_byte     (s_tdata),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    tcd_core #(
        .MESSAGE_BYTES (MESSAGE_BYTES)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .advance    (advance),
        .result     (result)
    );

    tcd_out_reg u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .result     (result),
        .load       (advance && result.valid),
        .load_ready (load_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .cmd_code   (cmd_code),
        .argument   (argument)
    );

    assign m_tdata = {4'h0, argument, cmd_code};

endmodule

/* rtl/tcd_checker.sv */
module tcd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // a stalled result holds still
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[3:0] <= 4'd8 && m_tdata[23:20] == 4'h0)
        else $error("command code out of range or padding set");

    // commands without an argument report zero
    a_no_arg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3:0] < 4'd5 |-> m_tdata[19:4] == 16'h0000)
        else $error("argument on a command that takes none");

    // mode and duty carry an 8 bit argument
    a_short_arg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[3:0] == 4'd5 || m_tdata[3:0] == 4'd7)
            |-> m_tdata[19:12] == 8'h00)
        else $error("8 bit argument wider than 8 bits");

endmodule

bind text_command_decoder tcd_checker u_tcd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
